/* hw/rtl/sha256_stream_hasher_defines.svh */
// Assertion macros for the SHA-256 stream hasher.
// Used by the top level only.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/sha_pkg.sv */
// Package for the SHA-256 stream hasher: payload types, states, round constants.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       final_req;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
    } t_core_state;

    typedef logic [31:0] t_hash [8];

    localparam logic [31:0] InitWords [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    function automatic logic [31:0] ror(input logic [31:0] v, input int s);
        ror = (v >> s) | (v << (32 - s));
    endfunction
endpackage

/* hw/rtl/sha256_stream_hasher.sv */
// SHA-256 stream hasher top level: input queue front end and compression core.
// Depends on sha_pkg, sha_front, sha_core and sha256_stream_hasher_defines.svh.
//
// Usage:
//   Input channel carries one message byte per word (data_byte, has_byte,
//   final_req). Words with neither flag set are dropped. A final word closes
//   the message; an empty message is a final word without a byte.
//   Output channel carries the eight digest words, word_index 0 first,
//   last_word set on the eighth.
// Sequence:
//   A byte that does not complete a block is written into the schedule window; one
//   that completes a 64-byte block is followed by the 64 rounds and the chain add.
//   A final word then pads one or two blocks, one padding byte per cycle, each
//   block followed by its rounds and chain add, then the eight digest words go
//   out. The core takes no new word until it is idle again.
//   A 4-deep input queue absorbs bursts.
// Reset: chaining words return to the initial values, count and queue empty.
// Output stall: the digest word holds; the core waits, the queue keeps
// accepting input until full.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher #(
    parameter int QUEUE_DEPTH = sha_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sha_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output sha_pkg::t_out_word o_data
);
    import sha_pkg::*;

    logic     w_qv, w_take;
    logic     w_last_acc;
    t_in_word w_qw;

    sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word(i_data),
        .o_valid(w_qv), .i_take(w_take), .o_word(w_qw)
    );

    sha_core u_core (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_take(w_take), .i_word(w_qw),
        .o_valid, .i_stall, .o_word(o_data)
    );

    assign w_last_acc = o_valid && !i_stall && o_data.last_word;

    `SHA_ASSERT_IMP(a_take_valid, i_clk, i_rst_n, w_take, w_qv, "take without queued word")
    `SHA_ASSERT_IMP(a_no_take_out, i_clk, i_rst_n, o_valid, !w_take, "input taken while emitting")
    `SHA_ASSERT_NXT(a_last_drop, i_clk, i_rst_n, w_last_acc, !o_valid, "extra digest word")
endmodule

/* hw/rtl/sha_front.sv */
// Front end: accepts input words and queues those that do work.
// Depends on sha_pkg. Words with neither flag set are dropped here.
`timescale 1ns / 1ps
module sha_front #(
    parameter int DEPTH = sha_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sha_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_take,
    output sha_pkg::t_in_word o_word
);
    import sha_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_in_word         r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [AW:0]      r_cnt, n_cnt;
    logic             w_push, w_pop, w_acc;

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign w_acc   = i_valid && !o_stall;
    assign w_push  = w_acc && (i_word.has_byte || i_word.final_req);
    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_take;
    assign o_word  = r_mem[r_rd];

    always_comb begin
        n_wr  = w_push ? ((r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = w_pop  ? ((r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_word;
        end
    end
endmodule

/* hw/rtl/sha_core.sv */
// Back end: block assembly in the schedule window, one round per cycle, padding,
// and digest output register. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_take,
    input  sha_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output sha_pkg::t_out_word o_word
);
    import sha_pkg::*;

    t_core_state  r_state, n_state;
    logic [31:0]  r_w [16];
    t_hash        r_h, r_v;
    logic [60:0]  r_cnt;
    logic [5:0]   r_rnd;
    logic [5:0]   r_pos;
    logic         r_fin, r_two;
    logic [2:0]   r_oi;
    logic         r_ov;
    logic [31:0]  r_od;

    logic [31:0] w_wt, w_t1, w_t2, w_s0, w_s1, w_new;
    logic        w_in_acc, w_blk;
    logic [7:0]  w_pb;
    logic [63:0] w_bits;

    assign w_in_acc = (r_state == ST_IDLE) && i_valid;
    assign o_take   = w_in_acc;
    assign w_blk    = i_word.has_byte && (r_cnt[5:0] == 6'd63);
    assign w_bits   = {r_cnt, 3'b000};

    // padding byte at position r_pos; r_two: another padding block follows
    always_comb begin
        w_pb = 8'h00;
        if (r_pos >= LenPos && !r_two) begin
            w_pb = w_bits[{~r_pos[2:0], 3'b000} +: 8];
        end else if (r_pos == r_cnt[5:0]) begin
            w_pb = PadByte;
        end
    end

    assign w_wt  = r_w[0];
    assign w_s0  = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1  = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + w_s0 + r_w[9] + w_s1;
    assign w_t1  = r_v[7] + (ror(r_v[4],6) ^ ror(r_v[4],11) ^ ror(r_v[4],25))
                 + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundConst[r_rnd] + w_wt;
    assign w_t2  = (ror(r_v[0],2) ^ ror(r_v[0],13) ^ ror(r_v[0],22))
                 + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_blk) n_state = ST_ROUND;
                    else if (i_word.final_req) n_state = ST_PAD;
                end
            end
            ST_PAD:   if (r_pos == 6'd63) n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'd63) n_state = ST_ADD;
            ST_ADD: begin
                if (!r_fin) n_state = ST_IDLE;
                else if (r_two) n_state = ST_PAD;
                else n_state = ST_EMIT;
            end
            ST_EMIT:  if (r_ov && !i_stall && r_oi == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_ov;
    always_comb begin
        o_word.digest_word = r_od;
        o_word.word_index  = r_oi;
        o_word.last_word   = (r_oi == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h     <= InitWords;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_oi    <= '0;
            r_rnd   <= '0;
            r_pos   <= '0;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_fin <= i_word.final_req;
                        r_rnd <= '0;
                        if (i_word.has_byte) r_cnt <= r_cnt + 61'd1;
                        if (w_blk) begin
                            r_pos <= '0;
                        end else if (i_word.has_byte) begin
                            r_pos <= r_cnt[5:0] + 6'd1;
                            r_two <= (r_cnt[5:0] + 6'd1) >= LenPos;
                        end else begin
                            r_pos <= r_cnt[5:0];
                            r_two <= r_cnt[5:0] >= LenPos;
                        end
                        if (w_blk && i_word.final_req) r_two <= 1'b1;
                    end
                end
                ST_PAD: begin
                    r_pos <= r_pos + 6'd1;
                    r_rnd <= '0;
                end
                ST_ROUND: r_rnd <= r_rnd + 6'd1;
                ST_ADD: begin
                    if (r_fin && r_two) begin
                        r_two <= 1'b0;
                        r_pos <= '0;
                    end
                    if (r_fin && !r_two) begin
                        r_ov <= 1'b1;
                        r_oi <= '0;
                        r_od <= r_h[0] + r_v[0];
                    end
                end
                ST_EMIT: begin
                    if (r_ov && !i_stall) begin
                        if (r_oi == 3'd7) begin
                            r_ov  <= 1'b0;
                            r_h   <= InitWords;
                            r_cnt <= '0;
                        end else begin
                            r_oi <= r_oi + 3'd1;
                            r_od <= r_h[r_oi + 3'd1];
                        end
                    end
                end
                default: ;
            endcase
            if (r_state == ST_ADD) begin
                for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
            end
        end
    end

    // payload: bytes land in the schedule window, working variables
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_word.has_byte) begin
            r_w[r_cnt[5:2]][{~r_cnt[1:0], 3'b000} +: 8] <= i_word.data_byte;
        end
        if (r_state == ST_PAD) begin
            r_w[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= w_pb;
        end
        if (n_state == ST_ROUND && r_state != ST_ROUND) begin
            r_v <= r_h;
        end else if (r_state == ST_ROUND) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end
endmodule

/* tb/sha256_digest_checker.sv */
// Digest checker for the SHA-256 stream hasher: watches both channels, predicts digests.
// Depends on sha_pkg for the word types.
`timescale 1ns / 1ps
module sha256_digest_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  sha_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  sha_pkg::t_out_word i_out_data,
    output int                 o_errors,
    output int                 o_pending
);
    import sha_pkg::*;

    localparam logic [31:0] K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    logic [60:0] nbytes;
    t_out_word   digest_q [$];
    int          errors;
    int          pending;

    assign o_errors  = errors;
    assign o_pending = pending;

    function automatic logic [31:0] rotr(logic [31:0] v, int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        a = chain;
        for (int i = 0; i < 64; i++) begin
            t1 = a[7] + (rotr(a[4], 6) ^ rotr(a[4], 11) ^ rotr(a[4], 25))
               + ((a[4] & a[5]) ^ (~a[4] & a[6])) + K[i] + w[i];
            t2 = (rotr(a[0], 2) ^ rotr(a[0], 13) ^ rotr(a[0], 22))
               + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
            a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
            a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += a[i];
    endtask

    task automatic absorb_word(t_in_word wd);
        logic [63:0] bitlen;
        int          p;
        t_out_word   r;
        if (wd.has_byte) begin
            blk[nbytes[5:0]] = wd.data_byte;
            nbytes = nbytes + 1'b1;
            if (nbytes[5:0] == 0) compress();
        end
        if (wd.final_req) begin
            bitlen = {nbytes, 3'b000};
            p = nbytes[5:0];
            blk[p] = 8'h80;
            p++;
            if (p > 56) begin
                while (p < 64) begin
                    blk[p] = 8'h00;
                    p++;
                end
                compress();
                p = 0;
            end
            while (p < 56) begin
                blk[p] = 8'h00;
                p++;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = bitlen[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                r.digest_word = chain[i];
                r.word_index  = 3'(i);
                r.last_word   = (i == 7);
                digest_q = {digest_q, r};
            end
            chain = H0;
            nbytes = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            chain = H0;
            nbytes = '0;
            errors = 0;
            digest_q.delete();
            pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    $error("digest word with none expected: %h", i_out_data);
                    errors++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (i_out_data.digest_word !== exp_w.digest_word) begin
                        $error("digest_word exp %h got %h", exp_w.digest_word,
                               i_out_data.digest_word);
                        errors++;
                    end
                    if (i_out_data.word_index !== exp_w.word_index) begin
                        $error("word_index exp %0d got %0d", exp_w.word_index,
                               i_out_data.word_index);
                        errors++;
                    end
                    if (i_out_data.last_word !== exp_w.last_word) begin
                        $error("last_word exp %b got %b", exp_w.last_word,
                               i_out_data.last_word);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) absorb_word(i_in_data);
            pending = digest_q.size();
        end
    end
endmodule

/* tb/tb_sha256_stream_hasher.sv */
// Testbench top for the SHA-256 stream hasher: byte-stream stimulus and verdict.
// Depends on sha_pkg, sha256_stream_hasher and sha256_digest_checker.
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;
    import sha_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;
    int        errors;
    int        pending;
    int        hold_cycles;
    bit        stim_done;

    sha256_stream_hasher u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_word),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_word));

    sha256_digest_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_word),
        .o_errors(errors), .o_pending(pending));

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one word, hold until taken, then a random gap if gaps is set
    task automatic send_word(logic [7:0] b, logic hb, logic fin, bit gaps);
        int g;
        in_valid <= 1'b1;
        in_word  <= '{data_byte: b, has_byte: hb, final_req: fin};
        do @(posedge clk); while (in_stall);
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_msg(int len, bit sep_final, bit gaps);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom), 1'b1, (i == len - 1) && !sep_final, gaps);
        if (sep_final || len == 0) send_word(8'($urandom), 1'b0, 1'b1, gaps);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // receiver: random stalls, plus one long forced hold
    initial begin
        int g;
        bit held;
        held = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_cycles > 0 && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
            end
            g = stim_done ? 0 : gap_len();
            if ($urandom_range(0, 3) == 0 && g > 0) begin
                out_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int n;
        in_valid    = 1'b0;
        in_word     = '0;
        rst_n       = 1'b0;
        hold_cycles = 0;
        stim_done   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, all-zero / all-one bytes, ignored word, sizes
        send_word(8'hff, 1'b0, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b0, 1'b0);
        send_word(8'hff, 1'b1, 1'b0, 1'b0);
        send_word(8'h5a, 1'b0, 1'b1, 1'b0);
        send_word(8'haa, 1'b1, 1'b0, 1'b0);
        send_word(8'h55, 1'b1, 1'b1, 1'b0);
        drain();
        send_msg(55, 1'b0, 1'b0);
        send_msg(56, 1'b0, 1'b1);
        send_msg(64, 1'b0, 1'b1);
        drain();

        // long output hold while the sender keeps going
        hold_cycles = 600;
        for (int k = 0; k < 5; k++) send_msg(2, 1'b0, 1'b0);
        drain();

        n = 0;
        while (n < 34) begin
            int len;
            len = $urandom_range(0, 12);
            if ($urandom_range(0, 7) == 0) begin
                send_word(8'($urandom), 1'b0, 1'b0, 1'b1);
                n++;
            end
            send_msg(len, $urandom_range(0, 3) == 0, 1'b1);
            n += len + 1;
        end
        stim_done = 1'b1;
        drain();
        repeat (300) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sha_pkg.sv
hw/rtl/sha_front.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_stream_hasher.sv
tb/sha256_digest_checker.sv
tb/tb_sha256_stream_hasher.sv
